/* hw/rtl/sfla_pkg.sv */
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int ADDR_W         = 48;
  localparam int CNT_W          = 7;
  localparam int IDX_W          = 6;
  localparam int DEF_SLAB_BYTES = 65536;
  localparam int DEF_MAX_SLABS  = 64;

  // Input op codes; code 3 is unused and dropped at the front
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_ALLOCATED     = 4'd0,
    ST_OUT_OF_SLABS  = 4'd1,
    ST_COMMIT_FAILED = 4'd2,
    ST_FREED         = 4'd3,
    ST_NULL          = 4'd4,
    ST_NOT_OWNED     = 4'd5,
    ST_MISALIGNED    = 4'd6,
    ST_STACK_FULL    = 4'd7,
    ST_DECOMMIT      = 4'd8,
    ST_NOTHING       = 4'd9
  } status_t;

  typedef enum logic {
    REG_BASE_ADDRESS = 1'b0,
    REG_SLAB_COUNT   = 1'b1
  } reg_idx_t;

  // What the back end has to do with a classified item
  typedef enum logic [1:0] {
    K_ALLOC  = 2'd0,
    K_PUSH   = 2'd1,
    K_REJECT = 2'd2,
    K_SHRINK = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              commit_ok;
    logic [IDX_W-1:0]  idx;
    status_t           reject;
  } cmd_t;

endpackage

/* hw/rtl/sfla_front.sv */
`timescale 1ns / 1ps

module sfla_front #(
  parameter int SLAB_BYTES = sfla_pkg::DEF_SLAB_BYTES
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [sfla_pkg::ADDR_W-1:0] address,
  input  logic                        commit_ok,
  input  logic [sfla_pkg::ADDR_W-1:0] base_address,
  input  logic [sfla_pkg::CNT_W-1:0]  slab_count,
  output logic                        q_push,
  output sfla_pkg::cmd_t              q_cmd,
  input  logic                        q_full
);
  import sfla_pkg::*;

  localparam int SH   = $clog2(SLAB_BYTES);
  localparam int HI_W = ADDR_W - SH;

  logic [ADDR_W-1:0] offset;
  logic [HI_W-1:0]   slab_no;
  logic              owned;
  logic              misaligned;
  logic              known_op;

  always_comb begin
    offset     = address - base_address;
    slab_no    = offset[ADDR_W-1:SH];
    owned      = (address >= base_address) && (slab_no < HI_W'(slab_count));
    misaligned = offset[SH-1:0] != '0;
    known_op   = (op == OP_ALLOC) || (op == OP_FREE) || (op == OP_SHRINK);

    q_cmd.kind      = K_REJECT;
    q_cmd.commit_ok = commit_ok;
    q_cmd.idx       = offset[SH+IDX_W-1:SH];
    q_cmd.reject    = ST_NULL;
    case (op)
      OP_ALLOC: begin
        q_cmd.kind = K_ALLOC;
      end
      OP_FREE: begin
        if (address == '0) begin
          q_cmd.reject = ST_NULL;
        end else if (!owned) begin
          q_cmd.reject = ST_NOT_OWNED;
        end else if (misaligned) begin
          q_cmd.reject = ST_MISALIGNED;
        end else begin
          q_cmd.kind = K_PUSH;
        end
      end
      OP_SHRINK: begin
        q_cmd.kind = K_SHRINK;
      end
      default: begin
        q_cmd.kind = K_REJECT;
      end
    endcase
  end

  // Unknown op codes are taken and dropped here
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && known_op;

endmodule

/* hw/rtl/sfla_queue.sv */
`timescale 1ns / 1ps

module sfla_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfla_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sfla_pkg::cmd_t head,
  output logic           head_valid
);
  import sfla_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;

  assign full       = used == 2'd2;
  assign head_valid = used != 2'd0;
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/sfla_back.sv */
`timescale 1ns / 1ps

module sfla_back #(
  parameter int SLAB_BYTES = sfla_pkg::DEF_SLAB_BYTES,
  parameter int MAX_SLABS  = sfla_pkg::DEF_MAX_SLABS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sfla_pkg::ADDR_W-1:0] base_address,
  input  logic [sfla_pkg::CNT_W-1:0]  slab_count,
  input  logic                        rebuild,
  input  logic [sfla_pkg::CNT_W-1:0]  rebuild_count,
  input  sfla_pkg::cmd_t              head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  status,
  output logic [sfla_pkg::ADDR_W-1:0] slab_address,
  output logic                        commit_now,
  output logic                        last,
  output logic [sfla_pkg::CNT_W-1:0]  free_slabs,
  output logic [sfla_pkg::CNT_W-1:0]  used_slabs
);
  import sfla_pkg::*;

  localparam int SH = $clog2(SLAB_BYTES);
  localparam int AW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK_RD,
    S_WALK_EV,
    S_WALK_END
  } state_t;

  typedef struct packed {
    status_t           st;
    logic [ADDR_W-1:0] addr;
    logic              commit;
    logic              fin;
    logic [CNT_W-1:0]  free_n;
    logic [CNT_W-1:0]  used_n;
  } res_t;

  function automatic res_t mk_res(status_t st, logic [ADDR_W-1:0] a, logic cn, logic fin,
                                  logic [CNT_W-1:0] d, logic [CNT_W-1:0] cnt);
    mk_res = '{st, a, cn, fin, d, cnt - d};
  endfunction

  state_t            state;
  res_t              res;
  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  walk_k;
  logic [MAX_SLABS-1:0] committed;
  logic [MAX_SLABS-1:0] written;
  logic              cur_commit_ok;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  // Free stack; an entry never written since the last rebuild reads as its rebuild value
  logic [IDX_W-1:0]  mem [MAX_SLABS];
  logic [IDX_W-1:0]  rd_data;
  logic              rd_written;
  logic [CNT_W-1:0]  rd_k;

  logic              out_free;
  logic              rd_en;
  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  top_slot;
  logic              mem_we;
  logic [IDX_W-1:0]  slab_idx;
  logic [ADDR_W-1:0] idx_addr;
  logic              is_committed;
  logic              res_load;

  always_comb begin
    out_free     = !out_valid || out_ready;
    top_slot     = depth - CNT_W'(1);
    rd_en        = (state == S_IDLE) || (state == S_WALK_RD);
    rd_addr      = (state == S_IDLE) ? top_slot : walk_k;
    pop          = (state == S_IDLE) && head_valid && out_free;
    mem_we       = pop && (head.kind == K_PUSH) && (depth < slab_count);
    slab_idx     = rd_written ? rd_data : IDX_W'(slab_count - CNT_W'(1) - rd_k);
    idx_addr     = base_address + (ADDR_W'(slab_idx) << SH);
    is_committed = committed[slab_idx[AW-1:0]];
    // a result is loaded into the output register this cycle
    res_load     = (pop && (head.kind != K_SHRINK)
                        && !((head.kind == K_ALLOC) && (depth != '0)))
                || ((state == S_ALLOC) && out_free)
                || ((state == S_WALK_EV) && is_committed && pend && out_free)
                || ((state == S_WALK_END) && out_free);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth[AW-1:0]] <= head.idx;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr[AW-1:0]];
      rd_written <= written[rd_addr[AW-1:0]];
      rd_k       <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= CNT_W'(MAX_SLABS);
      committed <= '0;
      written   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      walk_k    <= '0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur_commit_ok <= head.commit_ok;
            case (head.kind)
              K_ALLOC: begin
                if (depth == '0) begin
                  res <= mk_res(ST_OUT_OF_SLABS, '0, 1'b0, 1'b1, depth, slab_count);
                end else begin
                  state <= S_ALLOC;
                end
              end
              K_PUSH: begin
                if (depth >= slab_count) begin
                  res <= mk_res(ST_STACK_FULL, '0, 1'b0, 1'b1, depth, slab_count);
                end else begin
                  written[depth[AW-1:0]] <= 1'b1;
                  depth <= depth + CNT_W'(1);
                  res   <= mk_res(ST_FREED, '0, 1'b0, 1'b1, depth + CNT_W'(1), slab_count);
                end
              end
              K_SHRINK: begin
                walk_k <= '0;
                pend   <= 1'b0;
                state  <= S_WALK_RD;
              end
              default: begin
                res <= mk_res(head.reject, '0, 1'b0, 1'b1, depth, slab_count);
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (out_free) begin
            if (!is_committed && !cur_commit_ok) begin
              // leave the index on the stack
              res <= mk_res(ST_COMMIT_FAILED, '0, 1'b0, 1'b1, depth, slab_count);
            end else begin
              if (!is_committed) begin
                committed[slab_idx[AW-1:0]] <= 1'b1;
              end
              depth <= top_slot;
              res   <= mk_res(ST_ALLOCATED, idx_addr, !is_committed, 1'b1, top_slot,
                              slab_count);
            end
            state <= S_IDLE;
          end
        end
        S_WALK_RD: begin
          state <= (walk_k < depth) ? S_WALK_EV : S_WALK_END;
        end
        S_WALK_EV: begin
          if (!is_committed) begin
            walk_k <= walk_k + CNT_W'(1);
            state  <= S_WALK_RD;
          end else if (!pend || out_free) begin
            // hold one decommit back so that the final one can carry last
            if (pend) begin
              res <= mk_res(ST_DECOMMIT, pend_addr, 1'b0, 1'b0, depth, slab_count);
            end
            pend      <= 1'b1;
            pend_addr <= idx_addr;
            committed[slab_idx[AW-1:0]] <= 1'b0;
            walk_k    <= walk_k + CNT_W'(1);
            state     <= S_WALK_RD;
          end
        end
        S_WALK_END: begin
          if (out_free) begin
            if (pend) begin
              res <= mk_res(ST_DECOMMIT, pend_addr, 1'b0, 1'b1, depth, slab_count);
            end else begin
              res <= mk_res(ST_NOTHING, '0, 1'b0, 1'b1, depth, slab_count);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (rebuild) begin
        depth     <= rebuild_count;
        committed <= '0;
        written   <= '0;
      end
    end
  end

  assign status       = res.st;
  assign slab_address = res.addr;
  assign commit_now   = res.commit;
  assign last         = res.fin;
  assign free_slabs   = res.free_n;
  assign used_slabs   = res.used_n;

endmodule

/* hw/rtl/slab_free_list_allocator_core.sv */
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// cfg      cfg_write               cfg_index, cfg_data
// in       in_valid / in_ready     op, address, commit_ok
// out      out_valid / out_ready   status, slab_address, commit_now, last, free_slabs,
//                                  used_slabs
// An item passes the front in its accept cycle and waits in a two-entry queue.
// The back end finishes free and rejected items as it pops them; allocate does one free
// stack read, then the committed bit and the address add; shrink reads and checks each stack
// entry walked, then ends. Reset and a slab_count write take effect at once: per-entry
// written bits stand in for a rebuild, so there is no clearing pass. A stalled output
// register holds the back end; the queue keeps taking items until it is full.

module slab_free_list_allocator_core #(
  parameter int SLAB_BYTES = sfla_pkg::DEF_SLAB_BYTES,
  parameter int MAX_SLABS  = sfla_pkg::DEF_MAX_SLABS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [sfla_pkg::ADDR_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [sfla_pkg::ADDR_W-1:0] address,
  input  logic                        commit_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  status,
  output logic [sfla_pkg::ADDR_W-1:0] slab_address,
  output logic                        commit_now,
  output logic                        last,
  output logic [sfla_pkg::CNT_W-1:0]  free_slabs,
  output logic [sfla_pkg::CNT_W-1:0]  used_slabs
);
  import sfla_pkg::*;

  logic [ADDR_W-1:0] base_address;
  logic [CNT_W-1:0]  slab_count;
  logic [CNT_W-1:0]  count_next;
  logic              rebuild;

  logic              q_push;
  cmd_t              q_cmd;
  logic              q_full;
  logic              q_pop;
  cmd_t              q_head;
  logic              q_head_valid;

  // Clamp the slab count into one to MAX_SLABS
  always_comb begin
    count_next = cfg_data[CNT_W-1:0];
    if (count_next == '0) begin
      count_next = CNT_W'(1);
    end else if (count_next > CNT_W'(MAX_SLABS)) begin
      count_next = CNT_W'(MAX_SLABS);
    end
    rebuild = cfg_write && (cfg_index == REG_SLAB_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      slab_count   <= CNT_W'(MAX_SLABS);
    end else if (cfg_write) begin
      if (cfg_index == REG_BASE_ADDRESS) begin
        base_address <= cfg_data;
      end else begin
        slab_count <= count_next;
      end
    end
  end

  sfla_front #(
    .SLAB_BYTES (SLAB_BYTES)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .address      (address),
    .commit_ok    (commit_ok),
    .base_address (base_address),
    .slab_count   (slab_count),
    .q_push       (q_push),
    .q_cmd        (q_cmd),
    .q_full       (q_full)
  );

  sfla_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  sfla_back #(
    .SLAB_BYTES (SLAB_BYTES),
    .MAX_SLABS  (MAX_SLABS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .base_address  (base_address),
    .slab_count    (slab_count),
    .rebuild       (rebuild),
    .rebuild_count (count_next),
    .head          (q_head),
    .head_valid    (q_head_valid),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slab_address  (slab_address),
    .commit_now    (commit_now),
    .last          (last),
    .free_slabs    (free_slabs),
    .used_slabs    (used_slabs)
  );

  a_commit_only_on_alloc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ALLOCATED) |-> !commit_now)
    else $error("commit_now set on a result that is not an allocation");

  a_address_only_when_slab: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ALLOCATED) && (status != ST_DECOMMIT)
      |-> (slab_address == '0))
    else $error("slab address on a result that names no slab");

  a_single_result_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DECOMMIT) |-> last)
    else $error("single-result item without last");

  a_quiet_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid && !q_head_valid)
    else $error("result or queued item left over from reset");

endmodule
